>>> rtl/escape_time_fractal_iterator_core_assert.svh
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator_core_assert
// Assertion macros used by the RTL of the escape-time iterator.
// ----------------------------------------------------------------------------
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ESCAPE_TIME_FRACTAL_ITERATOR_CORE_ASSERT_SVH
`define ESCAPE_TIME_FRACTAL_ITERATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ETF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ETF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/etf_pkg.sv
// ----------------------------------------------------------------------------
// etf_pkg
// Shared constants for the escape-time fractal iterator: default widths,
// reset values and configuration register indexes.
// ----------------------------------------------------------------------------
package etf_pkg;

    localparam int DEF_WORD_WIDTH  = 32;
    localparam int DEF_FRAC_BITS   = 28;
    localparam int DEF_COUNT_WIDTH = 16;

    // Widest digit of the second multiplier operand handled in one cycle.
    localparam int MUL_DIGIT_MAX = 32;

    localparam int MAX_ITER_RESET = 200;

    localparam int CFG_INDEX_WIDTH = 4;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_ITERATIONS = 4'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FRACTAL_MODE   = 4'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_JULIA_C_REAL   = 4'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_JULIA_C_IMAG   = 4'd3;

    localparam logic MODE_MANDELBROT = 1'b0;
    localparam logic MODE_JULIA      = 1'b1;

endpackage

>>> rtl/etf_channels.sv
// ----------------------------------------------------------------------------
// etf_channels
// Valid/ready channels of the iterator: complex points in, iteration counts out.
// ----------------------------------------------------------------------------
interface etf_point_if #(
    parameter int WORD_WIDTH = etf_pkg::DEF_WORD_WIDTH
);
    logic                         valid;
    logic                         ready;
    logic signed [WORD_WIDTH-1:0] point_real;
    logic signed [WORD_WIDTH-1:0] point_imag;

    modport source (output valid, output point_real, output point_imag, input ready);
    modport sink   (input valid, input point_real, input point_imag, output ready);
endinterface

interface etf_result_if #(
    parameter int COUNT_WIDTH = etf_pkg::DEF_COUNT_WIDTH
);
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] iteration_count;

    modport source (output valid, output iteration_count, input ready);
    modport sink   (input valid, input iteration_count, output ready);
endinterface

>>> rtl/escape_time_fractal_iterator_core.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator_core
// Escape-time iterator for Mandelbrot and Julia sets in signed fixed point.
// ----------------------------------------------------------------------------
// A point beat on the point channel starts one escape-time run; exactly one
// beat with the iteration count follows on the result channel.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, as the block itself does not enforce this. One
// signed multiplier (WORD_WIDTH by a digit of up to 32 bits) serves all
// products; the second operand is split into D = ceil(WORD_WIDTH/32) digits.
// Each update forms zr*zr, zi*zi and zr*zi in turn, tests the bailout on
// the squares, then writes the new real and then the new imaginary part; an
// escaping point finishes after the test. A new point is taken only once the
// previous one has reached the result register.
// point.ready is high only while no point is in flight. A finished count
// waits in the result register; the next point is accepted meanwhile, and
// its own result waits until the receiver has taken the earlier beat.
// Reset clears the sequencer and the result valid flag and restores the
// configuration defaults (200 steps, Mandelbrot mode, Julia c = i).
// ----------------------------------------------------------------------------
module escape_time_fractal_iterator_core #(
    parameter int WORD_WIDTH  = etf_pkg::DEF_WORD_WIDTH,
    parameter int FRAC_BITS   = etf_pkg::DEF_FRAC_BITS,
    parameter int COUNT_WIDTH = etf_pkg::DEF_COUNT_WIDTH,
    localparam int CFG_WIDTH  = (WORD_WIDTH > COUNT_WIDTH) ? WORD_WIDTH : COUNT_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    etf_point_if.sink                           point,
    etf_result_if.source                        result,
    input  logic                                cfg_we,
    input  logic [etf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]                cfg_data
);

    localparam int W       = WORD_WIDTH;
    localparam int DIG_W   = (W < etf_pkg::MUL_DIGIT_MAX) ? W : etf_pkg::MUL_DIGIT_MAX;
    localparam int NUM_DIG = (W + DIG_W - 1) / DIG_W;
    localparam int BEXT_W  = NUM_DIG * DIG_W;
    localparam int MUL_W   = W + DIG_W + 1;
    localparam int PROD_W  = 2 * W;
    localparam int ACCX_W  = 2 * W + 1;
    localparam int SUM_W   = 2 * W + 2;
    localparam int RAD_W   = 2 * W + 3;
    localparam int DC_W    = $clog2(NUM_DIG + 1);

    localparam logic [DC_W-1:0]  DC_TOP = DC_W'(NUM_DIG - 1);
    localparam logic [RAD_W-1:0] BAIL   = RAD_W'(1) << (2 * FRAC_BITS + 2);

    localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RST = COUNT_WIDTH'(etf_pkg::MAX_ITER_RESET);
    localparam logic [W-1:0]           JCI_RST      = W'(64'd1 << FRAC_BITS);

    localparam logic signed [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL_RR = 3'd1;
    localparam logic [2:0] S_MUL_II = 3'd2;
    localparam logic [2:0] S_MUL_RI = 3'd3;
    localparam logic [2:0] S_CHECK  = 3'd4;
    localparam logic [2:0] S_UPD_R  = 3'd5;
    localparam logic [2:0] S_UPD_I  = 3'd6;
    localparam logic [2:0] S_FINISH = 3'd7;

    // Configuration registers.
    logic [COUNT_WIDTH-1:0] max_iter_reg;
    logic                   mode_reg;
    logic signed [W-1:0]    jcr_reg;
    logic signed [W-1:0]    jci_reg;

    // Sequencer.
    logic [2:0]             state_reg, state_next;
    logic [DC_W-1:0]        dcnt_reg, dcnt_next;
    logic [COUNT_WIDTH-1:0] step_reg, step_next;
    logic                   out_valid_reg, out_valid_next;
    logic [COUNT_WIDTH-1:0] out_count_reg;

    // Datapath.
    logic signed [W-1:0]      zr_reg, zi_reg, cr_reg, ci_reg;
    logic signed [PROD_W-1:0] acc_reg, rr_reg, ii_reg, ri_reg;
    logic signed [SUM_W-1:0]  diff_reg;

    logic                     accept;
    logic                     out_free;
    logic                     mul_busy;
    logic                     last_digit;
    logic signed [W-1:0]      mul_a, mul_b;
    logic signed [BEXT_W-1:0] mul_b_ext;
    logic [BEXT_W-1:0]        digit_shift;
    logic [DIG_W-1:0]         digit;
    logic signed [DIG_W:0]    mul_d;
    logic signed [MUL_W-1:0]  pp;
    logic signed [ACCX_W-1:0] acc_sum;
    logic signed [PROD_W-1:0] product;
    logic [RAD_W-1:0]         rad;
    logic                     escape;
    logic signed [SUM_W-1:0]  upd_term, upd_c, upd_sum;
    logic signed [W-1:0]      upd_sat;

    function automatic logic signed [W-1:0] saturate(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-W:0] upper;
        upper = v[SUM_W-1:W-1];
        if ((&upper) || !(|upper)) begin
            return v[W-1:0];
        end
        else if (v[SUM_W-1]) begin
            return SAT_MIN;
        end
        else begin
            return SAT_MAX;
        end
    endfunction

    assign accept   = point.valid && point.ready;
    assign out_free = !out_valid_reg || result.ready;

    assign point.ready            = (state_reg == S_IDLE);
    assign result.valid           = out_valid_reg;
    assign result.iteration_count = out_count_reg;

    // ------------------------------------------------------------------
    // Shared multiplier: the second operand is consumed one digit per
    // cycle, top (signed) digit first, and folded into the accumulator.
    // ------------------------------------------------------------------
    always_comb
    begin
        case (state_reg)
            S_MUL_RR:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            S_MUL_II:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
        endcase
    end

    assign mul_busy   = (state_reg == S_MUL_RR) || (state_reg == S_MUL_II) ||
                        (state_reg == S_MUL_RI);
    assign last_digit = (dcnt_reg == '0);

    assign mul_b_ext   = BEXT_W'(mul_b);
    assign digit_shift = mul_b_ext >> (dcnt_reg * DIG_W);
    assign digit       = digit_shift[DIG_W-1:0];
    assign mul_d       = (dcnt_reg == DC_TOP) ? {digit[DIG_W-1], digit} : {1'b0, digit};
    assign pp          = mul_a * mul_d;

    always_comb
    begin
        if (dcnt_reg == DC_TOP) begin
            acc_sum = ACCX_W'(pp);
        end
        else begin
            acc_sum = (ACCX_W'(acc_reg) <<< DIG_W) + ACCX_W'(pp);
        end
    end

    assign product = acc_sum[PROD_W-1:0];

    // Bailout test on the exact squares; equal to four does not escape.
    assign rad    = RAD_W'($unsigned(rr_reg)) + RAD_W'($unsigned(ii_reg));
    assign escape = (rad > BAIL);

    // Shared update adder: new real part, then new imaginary part.
    always_comb
    begin
        if (state_reg == S_UPD_R) begin
            upd_term = diff_reg >>> FRAC_BITS;
            upd_c    = SUM_W'(cr_reg);
        end
        else begin
            upd_term = SUM_W'(ri_reg) >>> (FRAC_BITS - 1);
            upd_c    = SUM_W'(ci_reg);
        end
    end

    assign upd_sum = upd_term + upd_c;
    assign upd_sat = saturate(upd_sum);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        dcnt_next      = DC_TOP;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !result.ready;
        case (state_reg)
            S_IDLE:
            begin
                if (accept) begin
                    step_next  = '0;
                    state_next = (max_iter_reg == '0) ? S_FINISH : S_MUL_RR;
                end
            end
            S_MUL_RR, S_MUL_II, S_MUL_RI:
            begin
                if (last_digit) begin
                    if (state_reg == S_MUL_RR) begin
                        state_next = S_MUL_II;
                    end
                    else if (state_reg == S_MUL_II) begin
                        state_next = S_MUL_RI;
                    end
                    else begin
                        state_next = S_CHECK;
                    end
                end
                else begin
                    dcnt_next = dcnt_reg - DC_W'(1);
                end
            end
            S_CHECK:
            begin
                state_next = escape ? S_FINISH : S_UPD_R;
            end
            S_UPD_R:
            begin
                state_next = S_UPD_I;
            end
            S_UPD_I:
            begin
                step_next  = step_reg + COUNT_WIDTH'(1);
                state_next = (step_next == max_iter_reg) ? S_FINISH : S_MUL_RR;
            end
            S_FINISH:
            begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            dcnt_reg      <= DC_TOP;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            max_iter_reg  <= MAX_ITER_RST;
            mode_reg      <= etf_pkg::MODE_MANDELBROT;
            jcr_reg       <= '0;
            jci_reg       <= JCI_RST;
        end
        else begin
            state_reg     <= state_next;
            dcnt_reg      <= dcnt_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    etf_pkg::CFG_MAX_ITERATIONS: max_iter_reg <= cfg_data[COUNT_WIDTH-1:0];
                    etf_pkg::CFG_FRACTAL_MODE:   mode_reg     <= cfg_data[0];
                    etf_pkg::CFG_JULIA_C_REAL:   jcr_reg      <= cfg_data[W-1:0];
                    etf_pkg::CFG_JULIA_C_IMAG:   jci_reg      <= cfg_data[W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            zr_reg <= point.point_real;
            zi_reg <= point.point_imag;
            if (mode_reg == etf_pkg::MODE_JULIA) begin
                cr_reg <= jcr_reg;
                ci_reg <= jci_reg;
            end
            else begin
                cr_reg <= point.point_real;
                ci_reg <= point.point_imag;
            end
        end
        if (mul_busy) begin
            acc_reg <= product;
            if (last_digit) begin
                case (state_reg)
                    S_MUL_RR: rr_reg <= product;
                    S_MUL_II: ii_reg <= product;
                    default:  ri_reg <= product;
                endcase
            end
        end
        if (state_reg == S_CHECK) begin
            diff_reg <= SUM_W'(rr_reg) - SUM_W'(ii_reg);
        end
        if (state_reg == S_UPD_R) begin
            zr_reg <= upd_sat;
        end
        if (state_reg == S_UPD_I) begin
            zi_reg <= upd_sat;
        end
        if ((state_reg == S_FINISH) && out_free) begin
            out_count_reg <= step_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`include "escape_time_fractal_iterator_core_assert.svh"

    `ETF_ASSERT_NEXT(a_zero_limit_finishes, accept && (max_iter_reg == '0),
                     state_reg == S_FINISH, "zero step limit did not finish at once")
    `ETF_ASSERT_NEXT(a_escape_finishes, (state_reg == S_CHECK) && escape,
                     state_reg == S_FINISH, "escaped point kept iterating")
    `ETF_ASSERT_NEXT(a_finish_delivers, (state_reg == S_FINISH) && out_free,
                     result.valid && (state_reg == S_IDLE),
                     "finished count not loaded into result register")
    `ETF_ASSERT_NEXT(a_product_advances, mul_busy && last_digit,
                     state_reg != $past(state_reg),
                     "sequencer stuck after last multiplier digit")
    `ETF_ASSERT_SAME(a_digit_only_in_mul, !mul_busy, dcnt_reg == DC_TOP,
                     "digit counter moved outside a product")

endmodule

>>> dv/tb_escape_time_fractal_iterator_core.sv
// ----------------------------------------------------------------------------
// tb_escape_time_fractal_iterator_core
// Self-checking bench for the escape-time iterator. A short list of directed
// points and register writes is followed by several randomized phases.
// Expected counts are given in the directed rows or come from a fixed-point model
// of the iteration kept in the bench, and each result beat is compared with the oldest expected count.
// ----------------------------------------------------------------------------
module tb_escape_time_fractal_iterator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W     = etf_pkg::DEF_WORD_WIDTH;
    localparam int F     = etf_pkg::DEF_FRAC_BITS;
    localparam int CW    = etf_pkg::DEF_COUNT_WIDTH;
    localparam int CFG_W = (W > CW) ? W : CW;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int LONG_STALL  = 3000;
    localparam int TAIL_CYCLES = 20;

    typedef logic [etf_pkg::CFG_INDEX_WIDTH-1:0] cfg_index_t;

    localparam cfg_index_t CFG_UNMAPPED = 4'd15;

    typedef logic signed [W-1:0]     word_t;
    typedef logic signed [2*W+1:0]   wide_t;
    typedef logic [CW-1:0]           count_t;
    typedef logic [CFG_W-1:0]        cfg_word_t;

    localparam word_t  ONE_FX      = word_t'(1) <<< F;
    localparam word_t  TWO_FX      = ONE_FX <<< 1;
    localparam word_t  HALF_FX     = ONE_FX >>> 1;
    localparam word_t  WORD_MAX    = word_t'({1'b0, {(W-1){1'b1}}});
    localparam word_t  WORD_MIN    = ~WORD_MAX;
    localparam wide_t  WIDE_MAX    = WORD_MAX;
    localparam wide_t  WIDE_MIN    = WORD_MIN;
    localparam wide_t  BAILOUT     = wide_t'(1) <<< (2*F + 2);
    localparam count_t COUNT_FULL  = '1;
    localparam count_t RESET_LIMIT = count_t'(etf_pkg::MAX_ITER_RESET);

    typedef enum logic {ROW_POINT, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t                    kind;
        cfg_index_t                   index;
        cfg_word_t                    data;
        word_t                        re;
        word_t                        im;
        bit                           known;
        count_t                       count;
    } row_t;

    typedef struct {
        bit     known;
        count_t count;
    } offered_t;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_we;
    cfg_index_t                 cfg_index;
    cfg_word_t                  cfg_data;

    etf_point_if  #(.WORD_WIDTH(W))   point_bus ();
    etf_result_if #(.COUNT_WIDTH(CW)) count_bus ();

    escape_time_fractal_iterator_core #(
        .WORD_WIDTH  (W),
        .FRAC_BITS   (F),
        .COUNT_WIDTH (CW)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .point     (point_bus),
        .result    (count_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Copy of the configuration registers as the bench has written them.
    count_t limit_reg;
    logic   mode_reg;
    word_t  julia_re_reg;
    word_t  julia_im_reg;

    offered_t offered_points[$];
    count_t   pending_counts[$];

    int error_count   = 0;
    int cycle_count   = 0;
    int results_seen  = 0;
    bit quiet_phase   = 1'b0;
    bit stall_request = 1'b0;
    bit sender_lazy   = 1'b1;

    row_t directed_rows [28];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic wide_t clamp_word(wide_t v);
        if (v > WIDE_MAX)
            return WIDE_MAX;
        if (v < WIDE_MIN)
            return WIDE_MIN;
        return v;
    endfunction

    // Number of completed updates z = z^2 + c before |z|^2 exceeds four, capped at the step limit.
    function automatic count_t escape_count(word_t pr, word_t pi);
        wide_t zr, zi, cr, ci, rr, ii, nr, ni;
        int unsigned n;
        bit escaped;
        zr = pr;
        zi = pi;
        if (mode_reg == etf_pkg::MODE_JULIA)
        begin
            cr = julia_re_reg;
            ci = julia_im_reg;
        end
        else
        begin
            cr = zr;
            ci = zi;
        end
        n = 0;
        escaped = 1'b0;
        while (n < limit_reg && !escaped)
        begin
            rr = zr * zr;
            ii = zi * zi;
            if (rr + ii > BAILOUT)
                escaped = 1'b1;
            else
            begin
                nr = clamp_word(((rr - ii) >>> F) + cr);
                ni = clamp_word(((zr * zi) >>> (F - 1)) + ci);
                zr = nr;
                zi = ni;
                n++;
            end
        end
        return count_t'(n);
    endfunction

    function automatic word_t rand_near(int unsigned span);
        return word_t'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic row_t point_row(word_t re, word_t im, bit known, count_t count);
        row_t r;
        r.kind  = ROW_POINT;
        r.index = etf_pkg::CFG_MAX_ITERATIONS;
        r.data  = '0;
        r.re    = re;
        r.im    = im;
        r.known = known;
        r.count = count;
        return r;
    endfunction

    function automatic row_t write_row(cfg_index_t index, cfg_word_t data);
        row_t r;
        r = point_row('0, '0, 1'b0, '0);
        r.kind  = ROW_WRITE;
        r.index = index;
        r.data  = data;
        return r;
    endfunction

    task automatic note_mismatch(string what);
        error_count++;
        $display("mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    task automatic write_reg(cfg_index_t index, cfg_word_t data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            etf_pkg::CFG_MAX_ITERATIONS: limit_reg    = data[CW-1:0];
            etf_pkg::CFG_FRACTAL_MODE:   mode_reg     = data[0];
            etf_pkg::CFG_JULIA_C_REAL:   julia_re_reg = word_t'(data[W-1:0]);
            etf_pkg::CFG_JULIA_C_IMAG:   julia_im_reg = word_t'(data[W-1:0]);
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Drop valid and wait until every point has been answered.
    task automatic settle();
        point_bus.valid <= 1'b0;
        while (pending_counts.size() != 0 || offered_points.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_point(word_t re, word_t im, bit known, count_t count);
        offered_t o;
        int unsigned gap;
        o.known = known;
        o.count = count;
        offered_points.push_back(o);
        point_bus.valid      <= 1'b1;
        point_bus.point_real <= re;
        point_bus.point_imag <= im;
        do
            @(posedge clk);
        while (!point_bus.ready);
        if (!quiet_phase && sender_lazy && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 16);
            point_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Mostly points near the set; noise_pct of them use every bit of the word.
    // A nonzero cap redraws points that would run longer than cap steps.
    task automatic random_points(int num, int unsigned span, int unsigned noise_pct,
                                 int unsigned cap);
        word_t re, im;
        int k;
        for (k = 0; k < num; k++)
        begin
            if (k % 50 == 0)
                sender_lazy = $urandom_range(0, 1);
            do
            begin
                if ($urandom_range(0, 99) < noise_pct)
                begin
                    re = word_t'($urandom);
                    im = word_t'($urandom);
                end
                else
                begin
                    re = rand_near(span);
                    im = rand_near(span);
                end
            end
            while (cap != 0 && escape_count(re, im) > cap);
            send_point(re, im, 1'b0, '0);
        end
    endtask

    always @(posedge clk)
    begin
        offered_t o;
        count_t want;
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        if (rst_n)
        begin
            if (point_bus.valid && point_bus.ready)
            begin
                if (offered_points.size() == 0)
                    note_mismatch("point beat accepted that was never offered");
                else
                begin
                    o = offered_points.pop_front();
                    if (o.known)
                        pending_counts.push_back(o.count);
                    else
                        pending_counts.push_back(
                            escape_count(point_bus.point_real, point_bus.point_imag));
                end
            end
            if (count_bus.valid && count_bus.ready)
            begin
                results_seen++;
                if (pending_counts.size() == 0)
                    note_mismatch("result beat with no point outstanding");
                else
                begin
                    want = pending_counts.pop_front();
                    if (count_bus.iteration_count !== want)
                        note_mismatch($sformatf("result %0d: iteration_count %0d, expected %0d",
                                                results_seen, count_bus.iteration_count, want));
                end
            end
        end
    end

    // Result side: random stalls, one long hold-off on request, none at the end.
    initial
    begin
        count_bus.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (stall_request)
            begin
                stall_request = 1'b0;
                count_bus.ready <= 1'b0;
                repeat (LONG_STALL) @(posedge clk);
            end
            else if (quiet_phase || $urandom_range(0, 3) != 0)
            begin
                count_bus.ready <= 1'b1;
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(100, 400)) @(posedge clk);
                else
                    repeat ($urandom_range(1, 40)) @(posedge clk);
            end
            else
            begin
                count_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    initial
    begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_index            <= etf_pkg::CFG_MAX_ITERATIONS;
        cfg_data             <= '0;
        point_bus.valid      <= 1'b0;
        point_bus.point_real <= '0;
        point_bus.point_imag <= '0;
        limit_reg    = RESET_LIMIT;
        mode_reg     = etf_pkg::MODE_MANDELBROT;
        julia_re_reg = '0;
        julia_im_reg = ONE_FX;

        directed_rows = '{
            // Reset configuration: Mandelbrot, 200 steps.
            point_row('0, '0, 1'b1, RESET_LIMIT),
            point_row(WORD_MAX, WORD_MAX, 1'b1, '0),
            point_row(WORD_MIN, WORD_MIN, 1'b1, '0),
            // A radius of exactly two does not escape.
            point_row(TWO_FX, '0, 1'b1, count_t'(1)),
            point_row(-TWO_FX, '0, 1'b1, RESET_LIMIT),
            point_row(ONE_FX, '0, 1'b0, '0),
            point_row(WORD_MIN, '0, 1'b1, '0),
            point_row('0, TWO_FX, 1'b0, '0),
            // Julia mode with the reset constant i; only bit 0 of the mode counts.
            write_row(etf_pkg::CFG_FRACTAL_MODE, '1),
            point_row('0, '0, 1'b0, '0),
            point_row('0, ONE_FX, 1'b0, '0),
            // Extreme constants force the update to saturate.
            write_row(etf_pkg::CFG_JULIA_C_REAL, cfg_word_t'(WORD_MAX)),
            write_row(etf_pkg::CFG_JULIA_C_IMAG, cfg_word_t'(WORD_MIN)),
            point_row(ONE_FX + HALF_FX + (HALF_FX >>> 1), '0, 1'b0, '0),
            point_row('0, ONE_FX, 1'b0, '0),
            point_row('0, '0, 1'b0, '0),
            write_row(etf_pkg::CFG_FRACTAL_MODE,
                      cfg_word_t'({{(CFG_W-1){1'b1}}, etf_pkg::MODE_MANDELBROT})),
            // A write to an index past the register list changes nothing.
            write_row(CFG_UNMAPPED, cfg_word_t'(WORD_MAX)),
            write_row(etf_pkg::CFG_MAX_ITERATIONS, '0),
            point_row('0, '0, 1'b1, '0),
            point_row(WORD_MAX, WORD_MIN, 1'b1, '0),
            write_row(etf_pkg::CFG_MAX_ITERATIONS, cfg_word_t'(1)),
            point_row('0, '0, 1'b1, count_t'(1)),
            point_row(TWO_FX, '0, 1'b1, count_t'(1)),
            write_row(etf_pkg::CFG_MAX_ITERATIONS, cfg_word_t'(COUNT_FULL)),
            point_row(ONE_FX, '0, 1'b0, '0),
            // Just past the cusp at 1/4: escapes, but only after many steps.
            point_row((ONE_FX >>> 2) + (ONE_FX >>> 7), '0, 1'b0, '0),
            point_row(WORD_MIN, WORD_MAX, 1'b1, '0)
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                settle();
                write_reg(directed_rows[i].index, directed_rows[i].data);
            end
            else
                send_point(directed_rows[i].re, directed_rows[i].im,
                           directed_rows[i].known, directed_rows[i].count);
        end

        // Mandelbrot near the set, with the long result hold-off at the start.
        settle();
        write_reg(etf_pkg::CFG_MAX_ITERATIONS, cfg_word_t'(32));
        write_reg(etf_pkg::CFG_FRACTAL_MODE, cfg_word_t'(etf_pkg::MODE_MANDELBROT));
        stall_request = 1'b1;
        random_points(300, 32'h2000_0000, 10, 0);

        // Julia with a random constant near the unit disk.
        settle();
        write_reg(etf_pkg::CFG_MAX_ITERATIONS, cfg_word_t'(64));
        write_reg(etf_pkg::CFG_FRACTAL_MODE, cfg_word_t'(etf_pkg::MODE_JULIA));
        write_reg(etf_pkg::CFG_JULIA_C_REAL, cfg_word_t'(rand_near(32'h1000_0000)));
        write_reg(etf_pkg::CFG_JULIA_C_IMAG, cfg_word_t'(rand_near(32'h1000_0000)));
        random_points(300, 32'h2000_0000, 10, 0);

        // Short runs, mostly full-range words.
        settle();
        write_reg(etf_pkg::CFG_MAX_ITERATIONS, cfg_word_t'($urandom_range(1, 20)));
        write_reg(etf_pkg::CFG_FRACTAL_MODE, cfg_word_t'(etf_pkg::MODE_MANDELBROT));
        random_points(200, 32'h2000_0000, 60, 0);

        // Julia with the opposite extreme constants.
        settle();
        write_reg(etf_pkg::CFG_MAX_ITERATIONS, cfg_word_t'(255));
        write_reg(etf_pkg::CFG_FRACTAL_MODE, cfg_word_t'(etf_pkg::MODE_JULIA));
        write_reg(etf_pkg::CFG_JULIA_C_REAL, cfg_word_t'(WORD_MIN));
        write_reg(etf_pkg::CFG_JULIA_C_IMAG, cfg_word_t'(WORD_MAX));
        random_points(100, 32'h2000_0000, 20, 0);

        // Largest step limit, only points that escape within 400 steps.
        settle();
        write_reg(etf_pkg::CFG_MAX_ITERATIONS, cfg_word_t'(COUNT_FULL));
        write_reg(etf_pkg::CFG_FRACTAL_MODE, cfg_word_t'(etf_pkg::MODE_MANDELBROT));
        random_points(100, 32'h2800_0000, 10, 400);

        // Final stretch at full rate on both sides.
        settle();
        write_reg(etf_pkg::CFG_MAX_ITERATIONS, cfg_word_t'(40));
        write_reg(etf_pkg::CFG_FRACTAL_MODE, cfg_word_t'(etf_pkg::MODE_JULIA));
        write_reg(etf_pkg::CFG_JULIA_C_REAL, cfg_word_t'(rand_near(32'h1000_0000)));
        write_reg(etf_pkg::CFG_JULIA_C_IMAG, cfg_word_t'(rand_near(32'h1000_0000)));
        quiet_phase = 1'b1;
        random_points(250, 32'h2000_0000, 10, 0);

        settle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/etf_pkg.sv
rtl/etf_channels.sv
rtl/escape_time_fractal_iterator_core.sv
dv/tb_escape_time_fractal_iterator_core.sv
